FILE: rtl/core/pmte_pkg.sv
// Shared types and constants for the per-module timestamp extender.
`default_nettype none
package pmte_pkg;

    // Field widths of one frame header and of one result.
    localparam int CTR_W  = 32;
    localparam int MOD_W  = 5;
    localparam int SECS_W = 64;
    localparam int TIME_W = 64;

    // Number of tracked modules.
    localparam int MODULES = 32;

    // 62500000 ticks per second is 1953125 shifted left by five.
    localparam int            TICK_SHIFT = 5;
    localparam logic [20:0]   TICK_ODD   = 21'd1953125;

    // Packed stream and register port widths.
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 64;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_ROLLOVER    = 1'b0;
    localparam logic REG_SYNC_PERIOD = 1'b1;

    // Queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // One classified frame on its way to the back part.
    typedef struct packed {
        logic [CTR_W-1:0]  ctr;
        logic [MOD_W-1:0]  mod;
        logic [TIME_W-1:0] scaled;   // system_seconds * 62500000, wrapped
    } t_item;

endpackage : pmte_pkg
`default_nettype wire

FILE: rtl/core/pmte_front.sv
// Front part: accepts headers, drops unusable ones and scales the seconds.
`default_nettype none
module pmte_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_tvalid,
    output logic                       o_tready,
    input  wire logic [pmte_pkg::CTR_W-1:0]  i_ctr,
    input  wire logic [pmte_pkg::MOD_W-1:0]  i_mod,
    input  wire logic [pmte_pkg::SECS_W-1:0] i_secs,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output pmte_pkg::t_item            o_item
);
    import pmte_pkg::*;

    logic                r_valid;
    logic [CTR_W-1:0]    r_ctr;
    logic [MOD_W-1:0]    r_mod;
    logic [52:0]         r_plo;
    logic [31:0]         r_phi;
    logic                c_accept;
    logic                c_keep;
    logic [31:0]         c_hi;
    logic [TIME_W-1:0]   c_prod;

    assign o_tready = !r_valid || !i_q_full;
    assign o_push   = r_valid && !i_q_full;
    assign c_accept = i_tvalid && o_tready;

    // A frame is kept only once the system time is known and the module is tracked.
    assign c_keep = (i_secs != '0) && (32'(i_mod) < MODULES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (c_accept) begin
            r_valid <= c_keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // The 64-bit by 26-bit product is split into two narrow partial products.
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_ctr <= i_ctr;
            r_mod <= i_mod;
            r_plo <= 53'(i_secs[31:0]) * 53'(TICK_ODD);
            r_phi <= 32'(i_secs[63:32] * 32'(TICK_ODD));
        end
    end

    assign c_hi   = 32'({11'b0, r_plo[52:32]}) + r_phi;
    assign c_prod = {c_hi, r_plo[31:0]};

    assign o_item.ctr    = r_ctr;
    assign o_item.mod    = r_mod;
    assign o_item.scaled = {c_prod[TIME_W-1-TICK_SHIFT:0], {TICK_SHIFT{1'b0}}};

endmodule : pmte_front
`default_nettype wire

FILE: rtl/core/pmte_fifo.sv
// Short queue of classified frames between the front and back parts.
`default_nettype none
module pmte_fifo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  pmte_pkg::t_item  i_item,
    output logic             o_full,
    input  wire logic        i_pop,
    output pmte_pkg::t_item  o_item,
    output logic             o_empty
);
    import pmte_pkg::*;

    t_item               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr;
    logic [FIFO_AW-1:0]  r_rd;
    logic [FIFO_AW:0]    r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule : pmte_fifo
`default_nettype wire

FILE: rtl/core/pmte_back.sv
// Back part: per-module tracking, sync counting and timestamp assembly.
`default_nettype none
module pmte_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_empty,
    input  pmte_pkg::t_item            i_item,
    output logic                       o_pop,
    input  wire logic [31:0]           i_threshold,
    input  wire logic [31:0]           i_period,
    output logic                       o_tvalid,
    input  wire logic                  i_tready,
    output logic [pmte_pkg::TIME_W-1:0] o_full_time
);
    import pmte_pkg::*;

    // Tracking tables; an entry whose seen bit is clear reads as zero.
    logic                r_seen [MODULES];
    logic [CTR_W-1:0]    r_last [MODULES];
    logic [31:0]         r_cnt  [MODULES];
    logic [TIME_W-1:0]   r_run_start;
    logic                r_start_known;

    logic                r_a_valid;
    logic [TIME_W-1:0]   r_a_base;
    logic [CTR_W-1:0]    r_a_ctr;
    logic [31:0]         r_a_cnt;
    logic                r_b_valid;
    logic [TIME_W-1:0]   r_b_sum;
    logic [TIME_W-1:0]   r_b_prod;
    logic                r_c_valid;
    logic [TIME_W-1:0]   r_c_time;

    logic                c_ready_a;
    logic                c_ready_b;
    logic                c_ready_c;
    logic                c_seen;
    logic [CTR_W-1:0]    c_last;
    logic [31:0]         c_cnt;
    logic                c_roll;
    logic [31:0]         n_cnt;
    logic [TIME_W-1:0]   n_run_start;
    logic [TIME_W-1:0]   c_base;
    logic [TIME_W-1:0]   c_prod;

    assign c_ready_c = !r_c_valid || i_tready;
    assign c_ready_b = !r_b_valid || c_ready_c;
    assign c_ready_a = !r_a_valid || c_ready_b;
    assign o_pop     = !i_empty && c_ready_a;

    assign c_seen = r_seen[i_item.mod];
    assign c_last = c_seen ? r_last[i_item.mod] : '0;
    assign c_cnt  = c_seen ? r_cnt[i_item.mod]  : '0;

    // The compare is done at 33 bits so the sum never wraps.
    assign c_roll = c_seen &&
                    (({1'b0, i_item.ctr} + {1'b0, i_threshold}) < {1'b0, c_last});
    assign n_cnt  = c_cnt + 32'(c_roll);

    assign n_run_start = i_item.scaled - TIME_W'(i_item.ctr);
    assign c_base      = r_start_known ? r_run_start : n_run_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MODULES; i++) begin
                r_seen[i] <= 1'b0;
            end
            r_start_known <= 1'b0;
        end else if (o_pop) begin
            r_seen[i_item.mod] <= 1'b1;
            if (!r_start_known) begin
                r_start_known <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_last[i_item.mod] <= i_item.ctr;
            r_cnt[i_item.mod]  <= n_cnt;
            if (!r_start_known) begin
                r_run_start <= n_run_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (c_ready_a) begin
                r_a_valid <= !i_empty;
            end
            if (c_ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    assign c_prod = {32'b0, r_a_cnt} * {32'b0, i_period};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_base <= c_base;
            r_a_ctr  <= i_item.ctr;
            r_a_cnt  <= n_cnt;
        end
        if (r_a_valid && c_ready_b) begin
            r_b_sum  <= r_a_base + TIME_W'(r_a_ctr);
            r_b_prod <= c_prod;
        end
        if (r_b_valid && c_ready_c) begin
            r_c_time <= r_b_sum + r_b_prod;
        end
    end

    assign o_tvalid    = r_c_valid;
    assign o_full_time = r_c_time;

endmodule : pmte_back
`default_nettype wire

FILE: rtl/core/per_module_timestamp_extender.sv
// Top level of the per-module timestamp extender with its register port.
`default_nettype none
// Extends the 32-bit 62.5 MHz counter time of each frame header to a 64-bit
// timestamp in ticks. Headers arrive as beats on the s_axis side; a header
// whose system seconds are zero is dropped without a result, and so is one
// whose module number is not tracked. The first kept header fixes the run
// start as seconds times 62500000 minus its counter time; each module's first
// header yields run start plus counter time, and later headers of that module
// also add sync count times sync_period_ticks, where a sync is counted each
// time the counter falls back by more than rollover_threshold. All sums wrap
// at 64 bits. The block takes one beat per cycle unless the output stalls; a
// kept header passes the front register, the queue and the back stages on its
// way to m_axis. The back part's read-modify-write of the per-module tables
// sets the rate; a four-entry queue between the front (which scales the
// seconds) and the back lets either side stall on its own. Registers must be
// written only while no header is in flight (not enforced): rollover_threshold
// at byte address 0 and sync_period_ticks at byte address 4, both reset to 0.
module per_module_timestamp_extender (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // counter_time [31:0], module_index [36:32], system_seconds [100:37]
    input  wire logic [pmte_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // full_time [63:0]
    output logic [pmte_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pmte_pkg::APB_AW-1:0]      paddr,
    input  wire logic [pmte_pkg::APB_DW-1:0]      pwdata,
    output logic [pmte_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);
    import pmte_pkg::*;

    logic [31:0]  r_threshold;
    logic [31:0]  r_period;
    logic         c_wr;

    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_empty;
    t_item        q_in;
    t_item        q_out;

    // The register port never waits; the write lands on the access cycle.
    assign pready = 1'b1;
    assign c_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_period    <= '0;
        end else if (c_wr) begin
            case (paddr[2])
                REG_ROLLOVER:    r_threshold <= pwdata;
                REG_SYNC_PERIOD: r_period    <= pwdata;
                default:         r_threshold <= r_threshold;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROLLOVER:    prdata = r_threshold;
            REG_SYNC_PERIOD: prdata = r_period;
            default:         prdata = '0;
        endcase
    end

    // Front: accepts beats, drops unusable headers and scales the seconds.
    pmte_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_ctr    (s_axis_tdata[31:0]),
        .i_mod    (s_axis_tdata[36:32]),
        .i_secs   (s_axis_tdata[100:37]),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (q_in)
    );

    pmte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    // Back: table update, rollover counting and the final sums.
    pmte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_item      (q_out),
        .o_pop       (q_pop),
        .i_threshold (r_threshold),
        .i_period    (r_period),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_full_time (m_axis_tdata)
    );

endmodule : per_module_timestamp_extender
`default_nettype wire

FILE: rtl/core/pmte_checker.sv
// Port-level checks for the per-module timestamp extender and their binding.
`default_nettype none
module pmte_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    input  wire logic [pmte_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic [pmte_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pmte_pkg::APB_AW-1:0]      paddr,
    input  wire logic [pmte_pkg::APB_DW-1:0]      pwdata,
    input  wire logic [pmte_pkg::APB_DW-1:0]      prdata,
    input  wire logic                             pready
);
    import pmte_pkg::*;

    // A stalled result beat holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    // A register reads back what was just written to it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(psel && penable && pwrite && pready) && $past(i_rst_n) &&
         (paddr[2] == $past(paddr[2]))) |-> (prdata == $past(pwdata)))
        else $error("register read-back mismatch");

    // Reset clears both registers.
    assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (prdata == '0))
        else $error("register not cleared by reset");

    // No result is offered right after reset.
    assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result offered right after reset");

endmodule : pmte_checker

bind per_module_timestamp_extender pmte_checker u_pmte_checker (.*);
`default_nettype wire
